// File: src/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, character codes and helpers for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam int MAX_HEX_DIGITS = 8;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LVL_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] CH_BACKSLASH = 32'h0000_005C;
    localparam logic [31:0] CH_DQUOTE    = 32'h0000_0022;
    localparam logic [31:0] CH_SQUOTE    = 32'h0000_0027;
    localparam logic [31:0] CH_ZERO      = 32'h0000_0030;
    localparam logic [31:0] CH_E         = 32'h0000_0065;
    localparam logic [31:0] CH_T         = 32'h0000_0074;
    localparam logic [31:0] CH_R         = 32'h0000_0072;
    localparam logic [31:0] CH_N         = 32'h0000_006E;
    localparam logic [31:0] CH_X         = 32'h0000_0078;
    localparam logic [31:0] CH_NUL       = 32'h0000_0000;
    localparam logic [31:0] CH_ESC       = 32'h0000_001B;
    localparam logic [31:0] CH_TAB       = 32'h0000_0009;
    localparam logic [31:0] CH_CR        = 32'h0000_000D;
    localparam logic [31:0] CH_LF        = 32'h0000_000A;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX  = 2'd2
    } t_mode;

    typedef struct packed {
        logic        last_of_run;
        logic [31:0] bad_following;
        logic [31:0] bad_letter;
        logic        is_error;
        logic [31:0] decoded_char;
    } t_result;

    typedef struct packed {
        logic                   room2;
        logic [QUEUE_LVL_W-1:0] level;
    } t_queue_status;

    function automatic logic is_hex(input logic [31:0] c);
        return (c inside {[32'h30:32'h39], [32'h41:32'h46], [32'h61:32'h66]});
    endfunction

    function automatic logic [3:0] hex_digit(input logic [31:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c inside {[32'h30:32'h39]}) begin
            d = c[3:0];
        end else if (c inside {[32'h41:32'h46], [32'h61:32'h66]}) begin
            d = 4'(c[3:0] + 4'd9);
        end
        return d;
    endfunction

endpackage

// File: src/escape_sequence_decoder_top.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder_top
// Decodes a stream of UTF-32 characters and resolves backslash escapes.
//
// Channel   Dir  tdata (low bit up)                         tlast        tuser
// s_axis    in   code_point[31:0]                            end_of_text  -
// m_axis    out  decoded_char, bad_letter, bad_following     last_of_run  is_error
//
// A character is decoded combinationally as it leaves the input register.
// One character per cycle is sustained while m_axis_tready stays high and each gives at most one result;
// two-result characters are limited by the one-per-cycle output port.
// The input register advances only when the four-entry result queue has room
// for two results, so back pressure from the queue reaches s_axis_tready.
// Reset returns the decoder to idle and empties the queue.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // code_point[31:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // decoded_char, bad_letter, bad_following
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // is_error
);
    import esd_pkg::*;

    logic          r_in_valid;
    logic [31:0]   r_cp;
    logic          r_eot;
    logic          advance;
    t_result       res0, res1, out_res;
    logic [1:0]    push_count;
    t_queue_status q_status;

    assign advance       = r_in_valid && q_status.room2;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cp  <= s_axis_tdata;
            r_eot <= s_axis_tlast;
        end
    end

    esd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (advance),
        .i_code_point  (r_cp),
        .i_end_of_text (r_eot),
        .o_res0        (res0),
        .o_res1        (res1),
        .o_count       (push_count)
    );

    esd_out_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_res0       (res0),
        .i_res1       (res1),
        .o_status     (q_status),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_res        (out_res)
    );

    assign m_axis_tdata = {out_res.bad_following, out_res.bad_letter, out_res.decoded_char};
    assign m_axis_tlast = out_res.last_of_run;
    assign m_axis_tuser = out_res.is_error;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.level <= QUEUE_LVL_W'(QUEUE_DEPTH))
        else $error("result queue level exceeds its depth");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_count != 2'd0) |-> q_status.room2)
        else $error("results pushed without room in the queue");

    a_error_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("error result carries a decoded character");

    a_following_is_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[95:64] != 32'd0)) |->
            (m_axis_tuser && (m_axis_tdata[63:32] == CH_X)))
        else $error("following character reported outside a bad hex escape");

endmodule

// File: src/esd_decode.sv
// ----------------------------------------------------------------------------
// esd_decode
// Escape decoding state and the single-pass logic that turns one character
// into zero, one or two results.
// ----------------------------------------------------------------------------
module esd_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [31:0]      i_code_point,
    input  logic             i_end_of_text,
    output esd_pkg::t_result o_res0,
    output esd_pkg::t_result o_res1,
    output logic [1:0]       o_count
);
    import esd_pkg::*;

    t_mode       r_mode, n_mode;
    logic [31:0] r_acc, n_acc;
    logic [3:0]  r_cnt, n_cnt;
    t_result     res0, res1;
    logic [1:0]  num;
    logic        simple;
    logic [31:0] simple_val;

    always_comb begin
        simple     = 1'b1;
        simple_val = CH_NUL;
        case (i_code_point)
            CH_BACKSLASH: simple_val = CH_BACKSLASH;
            CH_DQUOTE:    simple_val = CH_DQUOTE;
            CH_SQUOTE:    simple_val = CH_SQUOTE;
            CH_ZERO:      simple_val = CH_NUL;
            CH_E:         simple_val = CH_ESC;
            CH_T:         simple_val = CH_TAB;
            CH_R:         simple_val = CH_CR;
            CH_N:         simple_val = CH_LF;
            default:      simple     = 1'b0;
        endcase
    end

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        res0   = '0;
        res1   = '0;
        num    = 2'd0;
        case (r_mode)
            MODE_ESC: begin
                n_mode = MODE_IDLE;
                if (simple) begin
                    res0.decoded_char = simple_val;
                    num = 2'd1;
                end else if (i_code_point == CH_X && !i_end_of_text) begin
                    n_mode = MODE_HEX;
                    n_acc  = '0;
                    n_cnt  = '0;
                end else begin
                    res0.is_error   = 1'b1;
                    res0.bad_letter = i_code_point;
                    num = 2'd1;
                end
            end
            MODE_HEX: begin
                if (is_hex(i_code_point)) begin
                    n_acc = {r_acc[27:0], hex_digit(i_code_point)};
                    n_cnt = 4'(r_cnt + 4'd1);
                    if (n_cnt >= 4'(MAX_HEX_DIGITS) || i_end_of_text) begin
                        res0.decoded_char = n_acc;
                        num    = 2'd1;
                        n_mode = MODE_IDLE;
                    end
                end else if (r_cnt == 4'd0) begin
                    res0.is_error      = 1'b1;
                    res0.bad_letter    = CH_X;
                    res0.bad_following = i_code_point;
                    num    = 2'd1;
                    n_mode = MODE_IDLE;
                end else begin
                    res0.decoded_char = r_acc;
                    num    = 2'd1;
                    n_mode = MODE_IDLE;
                    if (i_code_point == CH_BACKSLASH) begin
                        if (i_end_of_text) begin
                            res1.is_error = 1'b1;
                            num = 2'd2;
                        end else begin
                            n_mode = MODE_ESC;
                        end
                    end else begin
                        res1.decoded_char = i_code_point;
                        num = 2'd2;
                    end
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                if (i_code_point == CH_BACKSLASH) begin
                    if (i_end_of_text) begin
                        res0.is_error = 1'b1;
                        num = 2'd1;
                    end else begin
                        n_mode = MODE_ESC;
                    end
                end else begin
                    res0.decoded_char = i_code_point;
                    num = 2'd1;
                end
            end
        endcase
        res0.last_of_run = (num == 2'd1);
        res1.last_of_run = (num == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_cnt  <= '0;
        end else if (i_valid) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
        end
    end

    assign o_res0  = res0;
    assign o_res1  = res1;
    assign o_count = i_valid ? num : 2'd0;

endmodule

// File: src/esd_out_queue.sv
// ----------------------------------------------------------------------------
// esd_out_queue
// Small result queue that takes up to two results per cycle and hands out
// one per transaction.
// ----------------------------------------------------------------------------
module esd_out_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_push_count,
    input  esd_pkg::t_result       i_res0,
    input  esd_pkg::t_result       i_res1,
    output esd_pkg::t_queue_status o_status,
    output logic                   o_valid,
    input  logic                   i_ready,
    output esd_pkg::t_result       o_res
);
    import esd_pkg::*;

    t_result                r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr, n_wr;
    logic [QUEUE_PTR_W-1:0] r_rd, n_rd;
    logic [QUEUE_LVL_W-1:0] r_level, n_level;
    logic                   pop;
    logic [QUEUE_PTR_W-1:0] wr_next;

    assign pop     = (r_level != '0) && i_ready;
    assign wr_next = QUEUE_PTR_W'(r_wr + 1'b1);

    always_comb begin
        n_wr    = QUEUE_PTR_W'(r_wr + i_push_count);
        n_rd    = pop ? QUEUE_PTR_W'(r_rd + 1'b1) : r_rd;
        n_level = QUEUE_LVL_W'(r_level + i_push_count - {{(QUEUE_LVL_W-1){1'b0}}, pop});
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_entry[r_wr] <= i_res0;
        end
        if (i_push_count == 2'd2) begin
            r_entry[wr_next] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

    assign o_status.room2 = (r_level <= QUEUE_LVL_W'(QUEUE_DEPTH - 2));
    assign o_status.level = r_level;
    assign o_valid        = (r_level != '0);
    assign o_res          = r_entry[r_rd];

endmodule

// File: sim/esd_checker.sv
// ----------------------------------------------------------------------------
// esd_checker
// Watches both stream channels of the escape sequence decoder, predicts the
// decoded results of every accepted code point and compares each result
// transaction, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module esd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [31:0] i_in_tdata,    // code_point[31:0]
    input  logic        i_in_tlast,
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    input  logic [95:0] i_out_tdata,   // decoded_char, bad_letter, bad_following
    input  logic        i_out_tlast,
    input  logic        i_out_tuser,   // is_error
    output int          o_mismatches,
    output int          o_pending,
    output int          o_decoded_total,
    output int          o_error_total,
    output int          o_hex_total,
    output int          o_double_total
);
    timeunit 1ns;
    timeprecision 1ps;

    import esd_pkg::*;

    t_mode       decoder_mode;
    logic [31:0] hex_acc;
    logic [3:0]  hex_count;
    t_result     step_results[$];
    t_result     awaited_chars[$];

    function automatic int hex_nibble(input logic [31:0] c);
        if (c >= 32'h30 && c <= 32'h39) begin
            return int'(c - 32'h30);
        end
        if (c >= 32'h41 && c <= 32'h46) begin
            return int'(c - 32'h41) + 10;
        end
        if (c >= 32'h61 && c <= 32'h66) begin
            return int'(c - 32'h61) + 10;
        end
        return -1;
    endfunction

    task automatic push_result(input logic [31:0] ch, input logic err,
                               input logic [31:0] letter, input logic [31:0] following);
        t_result r;
        r.decoded_char  = ch;
        r.is_error      = err;
        r.bad_letter    = letter;
        r.bad_following = following;
        r.last_of_run   = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic decode_plain(input logic [31:0] c, input logic eot);
        decoder_mode = MODE_IDLE;
        if (c != CH_BACKSLASH) begin
            push_result(c, 1'b0, CH_NUL, CH_NUL);
        end else if (eot) begin
            push_result(CH_NUL, 1'b1, CH_NUL, CH_NUL);
        end else begin
            decoder_mode = MODE_ESC;
        end
    endtask

    task automatic predict_char(input logic [31:0] c, input logic eot);
        int digit;
        step_results.delete();
        case (decoder_mode)
            MODE_ESC: begin
                decoder_mode = MODE_IDLE;
                case (c)
                    CH_BACKSLASH, CH_DQUOTE, CH_SQUOTE: push_result(c, 1'b0, CH_NUL, CH_NUL);
                    CH_ZERO: push_result(CH_NUL, 1'b0, CH_NUL, CH_NUL);
                    CH_E:    push_result(CH_ESC, 1'b0, CH_NUL, CH_NUL);
                    CH_T:    push_result(CH_TAB, 1'b0, CH_NUL, CH_NUL);
                    CH_R:    push_result(CH_CR, 1'b0, CH_NUL, CH_NUL);
                    CH_N:    push_result(CH_LF, 1'b0, CH_NUL, CH_NUL);
                    default: begin
                        if (c == CH_X && !eot) begin
                            decoder_mode = MODE_HEX;
                            hex_acc      = '0;
                            hex_count    = '0;
                        end else begin
                            push_result(CH_NUL, 1'b1, c, CH_NUL);
                        end
                    end
                endcase
            end
            MODE_HEX: begin
                digit = hex_nibble(c);
                if (digit >= 0) begin
                    hex_acc   = {hex_acc[27:0], 4'(digit)};
                    hex_count = hex_count + 4'd1;
                    if (hex_count >= MAX_HEX_DIGITS || eot) begin
                        push_result(hex_acc, 1'b0, CH_NUL, CH_NUL);
                        decoder_mode = MODE_IDLE;
                        o_hex_total++;
                    end
                end else if (hex_count == 4'd0) begin
                    push_result(CH_NUL, 1'b1, CH_X, c);
                    decoder_mode = MODE_IDLE;
                end else begin
                    push_result(hex_acc, 1'b0, CH_NUL, CH_NUL);
                    o_hex_total++;
                    decode_plain(c, eot);
                end
            end
            default: decode_plain(c, eot);
        endcase
        if (step_results.size() > 0) begin
            step_results[step_results.size() - 1].last_of_run = 1'b1;
        end
        if (step_results.size() > 1) begin
            o_double_total++;
        end
        foreach (step_results[k]) begin
            if (step_results[k].is_error) begin
                o_error_total++;
            end
            awaited_chars.push_back(step_results[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            decoder_mode = MODE_IDLE;
            hex_acc      = '0;
            hex_count    = '0;
            awaited_chars.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                if (awaited_chars.size() == 0) begin
                    $error("Result transaction 0x%024h with no decoded character awaited",
                           i_out_tdata);
                    o_mismatches++;
                end else begin
                    want = awaited_chars.pop_front();
                    check_field("decoded_char", want.decoded_char, i_out_tdata[31:0]);
                    check_field("bad_letter", want.bad_letter, i_out_tdata[63:32]);
                    check_field("bad_following", want.bad_following, i_out_tdata[95:64]);
                    check_field("is_error", 32'(want.is_error), 32'(i_out_tuser));
                    check_field("last_of_run", 32'(want.last_of_run), 32'(i_out_tlast));
                    o_decoded_total++;
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                predict_char(i_in_tdata, i_in_tlast);
            end
        end
        o_pending = awaited_chars.size();
    end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives code point streams into the escape sequence decoder: a directed
// pass over the escape corner cases, then random text rich in simple, hex and
// malformed escapes, under bursty input, a stalling output and long hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import esd_pkg::*;

    localparam int          RANDOM_ITEMS   = 1300;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES   = 16;
    localparam logic [63:0] DIRECTED_HEX   = "DeadBeef";

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    int mismatches;
    int pending;
    int decoded_total;
    int error_total;
    int hex_total;
    int double_total;
    int chars_sent    = 0;
    int burst_left    = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int idle_cycles   = 0;

    escape_sequence_decoder_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    esd_checker decode_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_tvalid     (s_axis_tvalid),
        .i_in_tready     (s_axis_tready),
        .i_in_tdata      (s_axis_tdata),
        .i_in_tlast      (s_axis_tlast),
        .i_out_tvalid    (m_axis_tvalid),
        .i_out_tready    (m_axis_tready),
        .i_out_tdata     (m_axis_tdata),
        .i_out_tlast     (m_axis_tlast),
        .i_out_tuser     (m_axis_tuser),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_decoded_total (decoded_total),
        .o_error_total   (error_total),
        .o_hex_total     (hex_total),
        .o_double_total  (double_total)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : receiver
        int cycle_count;
        int stall_style;
        logic ready_next;
        cycle_count = 0;
        stall_style = 0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_served++;
            end
            if (cycle_count % 150 == 0) begin
                stall_style = $urandom_range(0, 3);
            end
            case (stall_style)
                0:       ready_next = 1'b1;
                1:       ready_next = 1'($urandom_range(0, 1));
                2:       ready_next = ($urandom_range(0, 3) == 0);
                default: ready_next = ((cycle_count % 7) < 4);
            endcase
            m_axis_tready <= ready_next;
            cycle_count++;
        end
    end

    function automatic logic [31:0] random_char();
        if ($urandom_range(0, 1) == 0) begin
            return 32'($urandom_range(0, 127));
        end
        return $urandom;
    endfunction

    function automatic logic random_eot();
        return ($urandom_range(0, 15) == 0);
    endfunction

    function automatic logic [31:0] escape_letter(input int k);
        case (k)
            0:       return CH_BACKSLASH;
            1:       return CH_DQUOTE;
            2:       return CH_SQUOTE;
            3:       return CH_ZERO;
            4:       return CH_E;
            5:       return CH_T;
            6:       return CH_R;
            default: return CH_N;
        endcase
    endfunction

    function automatic logic [31:0] random_hex_digit();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10) begin
            return 32'h30 + 32'(k);
        end else if (k < 16) begin
            return 32'h41 + 32'(k - 10);
        end
        return 32'h61 + 32'(k - 16);
    endfunction

    function automatic logic [31:0] non_hex_char();
        case ($urandom_range(0, 3))
            0:       return 32'($urandom_range(32'h67, 32'h7A));
            1:       return 32'($urandom_range(32'h47, 32'h5A));
            2:       return 32'($urandom_range(0, 32'h2F));
            default: return $urandom | 32'h0000_0100;
        endcase
    endfunction

    task automatic send_char(input logic [31:0] c, input logic eot);
        int gap;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        chars_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom;
                s_axis_tlast  <= 1'($urandom_range(0, 1));
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int target;
        int digits;
        int holds_asked;
        logic paused;
        holds_asked = 0;
        paused      = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_char(CH_NUL, 1'b0);
        send_char(CH_BACKSLASH, 1'b0);
        send_char(32'hFFFF_FFFF, 1'b0);
        send_char(CH_BACKSLASH, 1'b1);
        send_char(CH_BACKSLASH, 1'b0);
        send_char(CH_X, 1'b1);
        send_char(CH_BACKSLASH, 1'b0);
        send_char(CH_X, 1'b0);
        send_char("g", 1'b0);
        send_char(CH_BACKSLASH, 1'b0);
        send_char(CH_X, 1'b0);
        send_char("A", 1'b0);
        send_char(32'hFFFF_FFFF, 1'b0);
        send_char(CH_BACKSLASH, 1'b0);
        send_char(CH_X, 1'b0);
        send_char("f", 1'b0);
        send_char(CH_BACKSLASH, 1'b1);
        send_char(CH_BACKSLASH, 1'b0);
        send_char(CH_X, 1'b0);
        send_char("1", 1'b0);
        send_char(CH_BACKSLASH, 1'b0);
        send_char(CH_T, 1'b0);
        send_char(CH_BACKSLASH, 1'b0);
        send_char(CH_X, 1'b0);
        for (int i = 0; i < 8; i++) begin
            send_char(32'(DIRECTED_HEX[8 * (7 - i) +: 8]), 1'b0);
        end
        wait_for_results();

        target = chars_sent + RANDOM_ITEMS;
        while (chars_sent < target) begin
            if ((holds_asked == 0 && chars_sent >= 300) ||
                (holds_asked == 1 && chars_sent >= 900)) begin
                holds_asked++;
                hold_requests <= holds_asked;
            end
            if (!paused && chars_sent >= 650) begin
                paused = 1'b1;
                wait_for_results();
            end
            case ($urandom_range(0, 99)) inside
                [0:34]: send_char(random_char(), random_eot());
                [35:59]: begin
                    send_char(CH_BACKSLASH, 1'b0);
                    send_char(escape_letter($urandom_range(0, 7)), random_eot());
                end
                [60:84]: begin
                    send_char(CH_BACKSLASH, 1'b0);
                    send_char(CH_X, 1'b0);
                    digits = $urandom_range(1, MAX_HEX_DIGITS + 1);
                    repeat (digits) send_char(random_hex_digit(), random_eot());
                    case ($urandom_range(0, 3))
                        0: send_char(non_hex_char(), random_eot());
                        1: send_char(CH_BACKSLASH, 1'b1);
                        2: begin
                            send_char(CH_BACKSLASH, 1'b0);
                            send_char(escape_letter($urandom_range(0, 7)), random_eot());
                        end
                        default: ;
                    endcase
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: begin
                            send_char(CH_BACKSLASH, 1'b0);
                            send_char(random_char(), random_eot());
                        end
                        1: send_char(CH_BACKSLASH, 1'b1);
                        2: begin
                            send_char(CH_BACKSLASH, 1'b0);
                            send_char(CH_X, 1'b1);
                        end
                        default: begin
                            send_char(CH_BACKSLASH, 1'b0);
                            send_char(CH_X, 1'b0);
                            send_char(non_hex_char(), random_eot());
                        end
                    endcase
                end
            endcase
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d code points and checked %0d results: %0d escape errors,",
                 chars_sent, decoded_total, error_total);
        $display("%0d hex values, %0d code points with two results, %0d output hold-offs.",
                 hex_total, double_total, holds_served);
        if (mismatches == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
src/esd_pkg.sv
src/esd_decode.sv
src/esd_out_queue.sv
src/escape_sequence_decoder_top.sv
sim/esd_checker.sv
sim/tb_top.sv
